### hw/rtl/lbr_pkg.sv
// ----------------------------------------------------------------------------
// lbr_pkg
// shared types and constants of the letterbox nearest resize unit
// ----------------------------------------------------------------------------
`default_nettype none
package lbr_pkg;
  localparam int MAX_SRC_W_DEF   = 128;
  localparam int MAX_SRC_H_DEF   = 128;
  localparam int MAX_DST_DIM_DEF = 1024;

  localparam int SRC_REG_W = 8;
  localparam int DST_REG_W = 11;
  localparam int PAD_REG_W = 8;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int COORD_IN_W = 7;
  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 3 * CHAN_W;
  localparam int COL_W      = 10;
  localparam int FIFO_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_W  = 3'd0,
    CFG_SRC_H  = 3'd1,
    CFG_DST_W  = 3'd2,
    CFG_DST_H  = 3'd3,
    CFG_PAD    = 3'd4
  } cfg_idx_t;

  typedef enum logic [0:0] {
    FN_WRITE = 1'b0,
    FN_EMIT  = 1'b1
  } func_t;

  typedef struct packed {
    logic                  func;
    logic [COORD_IN_W-1:0] write_x;
    logic [COORD_IN_W-1:0] write_y;
    logic [CHAN_W-1:0]     red;
    logic [CHAN_W-1:0]     green;
    logic [CHAN_W-1:0]     blue;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DGO,
    ST_DWAIT,
    ST_OFFS,
    ST_POS,
    ST_READ,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    DK_RW,
    DK_RH,
    DK_SX,
    DK_SY
  } div_kind_t;
endpackage
`default_nettype wire

### hw/rtl/lbr_if.sv
// ----------------------------------------------------------------------------
// lbr_in_if / lbr_out_if
// valid/ready channels for source items and output pixels
// ----------------------------------------------------------------------------
`default_nettype none
interface lbr_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [6:0] write_x;
  logic [6:0] write_y;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  modport source (output valid, func, write_x, write_y, in_red, in_green, in_blue,
                  input ready);
  modport sink (input valid, func, write_x, write_y, in_red, in_green, in_blue,
                output ready);
endinterface

interface lbr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [9:0] col;
  logic [9:0] row;
  logic       is_padding;
  logic       frame_end;
  modport source (output valid, out_red, out_green, out_blue, col, row, is_padding,
                  frame_end, input ready);
  modport sink (input valid, out_red, out_green, out_blue, col, row, is_padding,
                frame_end, output ready);
endinterface
`default_nettype wire

### hw/rtl/lbr_front.sv
// ----------------------------------------------------------------------------
// lbr_front
// accepts items and queues them for the back end
// ----------------------------------------------------------------------------
`default_nettype none
module lbr_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  lbr_in_if.sink             in_ch,
  output lbr_pkg::item_t     head,
  output logic               head_valid,
  input  wire logic          pop
);
  import lbr_pkg::*;

  item_t     q_r [FIFO_DEPTH];
  logic      wp_r, rp_r;
  logic [1:0] cnt_r;
  logic      push;
  item_t     in_item;

  assign in_ch.ready = (cnt_r != 2'(FIFO_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign head_valid  = (cnt_r != 2'd0);
  assign head        = q_r[rp_r];

  always_comb begin
    in_item.func    = in_ch.func;
    in_item.write_x = in_ch.write_x;
    in_item.write_y = in_ch.write_y;
    in_item.red     = in_ch.in_red;
    in_item.green   = in_ch.in_green;
    in_item.blue    = in_ch.in_blue;
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= in_item;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid) else $error("pop from empty queue");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(FIFO_DEPTH)) else $error("queue overflow");
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 2'd1) else $error("lost item");
endmodule
`default_nettype wire

### hw/rtl/lbr_div.sv
// ----------------------------------------------------------------------------
// lbr_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module lbr_div #(
  parameter int NW   = 24,
  parameter int DENW = 12
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [NW-1:0]   num,
  input  wire logic [DENW-1:0] den,
  output logic                 done,
  output logic [NW-1:0]        quo
);
  localparam int CW = $clog2(NW + 1);

  logic [DENW-1:0] rem_r, den_r;
  logic [NW-1:0]   quo_r;
  logic [CW-1:0]   cnt_r;
  logic            busy_r, done_r;
  logic [DENW:0]   trial;
  logic            ge;

  assign trial = {rem_r, quo_r[NW-1]};
  assign ge    = (trial >= {1'b0, den_r});
  assign done  = done_r;
  assign quo   = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? DENW'(trial - {1'b0, den_r}) : DENW'(trial);
      quo_r <= {quo_r[NW-2:0], ge};
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) busy_r <= 1'b0;
      end
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("done while busy");
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider restarted while busy");
  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r == CW'(1)) |=> done_r) else $error("missing done");
endmodule
`default_nettype wire

### hw/rtl/lbr_back.sv
// ----------------------------------------------------------------------------
// lbr_back
// executes queued items: frame store writes and output pixel generation
// ----------------------------------------------------------------------------
`default_nettype none
module lbr_back #(
  parameter int MAX_SRC_W   = lbr_pkg::MAX_SRC_W_DEF,
  parameter int MAX_SRC_H   = lbr_pkg::MAX_SRC_H_DEF,
  parameter int MAX_DST_DIM = lbr_pkg::MAX_DST_DIM_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire lbr_pkg::item_t                head,
  input  wire logic                          head_valid,
  output logic                               pop,
  input  wire logic                          cfg_we,
  input  wire logic [lbr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lbr_pkg::CFG_DATA_W-1:0] cfg_data,
  lbr_out_if.source                          out_ch
);
  import lbr_pkg::*;

  localparam int DW_A = $clog2(MAX_SRC_W + 1) > $clog2(MAX_SRC_H + 1) ?
                        $clog2(MAX_SRC_W + 1) : $clog2(MAX_SRC_H + 1);
  localparam int DW   = DW_A > $clog2(MAX_DST_DIM + 1) ? DW_A : $clog2(MAX_DST_DIM + 1);
  localparam int NW   = 2 * DW + 2;
  localparam int DENW = DW + 1;
  localparam int DEPTH = MAX_SRC_W * MAX_SRC_H;
  localparam int AW   = $clog2(DEPTH);

  // configuration
  logic [SRC_REG_W-1:0] src_w_r, src_h_r;
  logic [DST_REG_W-1:0] dst_w_r, dst_h_r;
  logic [PAD_REG_W-1:0] pad_r;

  // setup and cursor
  logic [DW-1:0] sw_r, sh_r, tw_r, th_r, sn_r, sd_r;
  logic [DW-1:0] rw_r, rh_r, offx_r, offy_r, cx_r, cy_r, sx_r;
  logic          setup_valid_r, is_pad_r;
  div_kind_t     kind_r;
  state_t        state_r, state_nxt;

  // store
  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_data_r;
  logic [AW-1:0]    rd_addr_r;

  // output register
  logic             ov_r;
  logic [PIX_W-1:0] opix_r;
  logic [COL_W-1:0] ocol_r, orow_r;
  logic             opad_r, olast_r;

  // divider
  logic            div_start, div_done;
  logic [NW-1:0]   div_num, div_q;
  logic [DENW-1:0] div_den;

  logic [DW-1:0] sw_c, sh_c, tw_c, th_c, cx_e, cy_e, u_c, v_c, q_clamp;
  logic          pad_c, last_c, wr_en, out_free, cfg_hit;
  logic [AW-1:0] wr_addr;

  function automatic logic [DW-1:0] sat(input logic [DST_REG_W-1:0] v, input int hi);
    logic [DW-1:0] r;
    if (v == '0) r = DW'(1);
    else if (32'(v) > hi) r = DW'(hi);
    else r = DW'(v);
    return r;
  endfunction

  assign sw_c = sat(DST_REG_W'(src_w_r), MAX_SRC_W);
  assign sh_c = sat(DST_REG_W'(src_h_r), MAX_SRC_H);
  assign tw_c = sat(dst_w_r, MAX_DST_DIM);
  assign th_c = sat(dst_h_r, MAX_DST_DIM);

  // cursor wraps if it was left outside the frame
  assign cx_e = (cx_r >= tw_r || cy_r >= th_r) ? '0 : cx_r;
  assign cy_e = (cx_r >= tw_r || cy_r >= th_r) ? '0 : cy_r;
  assign pad_c = !(cx_e >= offx_r && (cx_e - offx_r) < rw_r &&
                   cy_e >= offy_r && (cy_e - offy_r) < rh_r);
  assign u_c = cx_r - offx_r;
  assign v_c = cy_r - offy_r;
  assign last_c = (cx_r == tw_r - DW'(1)) && (cy_r == th_r - DW'(1));
  assign out_free = !ov_r || out_ch.ready;
  assign wr_addr = AW'(32'(head.write_y) * MAX_SRC_W + 32'(head.write_x));
  assign cfg_hit = cfg_we && (cfg_index == CFG_SRC_W || cfg_index == CFG_SRC_H ||
                   cfg_index == CFG_DST_W || cfg_index == CFG_DST_H || cfg_index == CFG_PAD);

  always_comb begin
    case (kind_r)
      DK_RW: begin
        div_num = ((NW'(sw_r) * NW'(sn_r)) << 1) + NW'(sd_r);
        div_den = {sd_r, 1'b0};
      end
      DK_RH: begin
        div_num = ((NW'(sh_r) * NW'(sn_r)) << 1) + NW'(sd_r);
        div_den = {sd_r, 1'b0};
      end
      DK_SX: begin
        div_num = ((NW'(u_c) << 1) + NW'(1)) * NW'(sd_r);
        div_den = {sn_r, 1'b0};
      end
      default: begin
        div_num = ((NW'(v_c) << 1) + NW'(1)) * NW'(sd_r);
        div_den = {sn_r, 1'b0};
      end
    endcase
    case (kind_r)
      DK_RW:   q_clamp = (div_q > NW'(tw_r)) ? tw_r : DW'(div_q);
      DK_RH:   q_clamp = (div_q > NW'(th_r)) ? th_r : DW'(div_q);
      DK_SX:   q_clamp = (div_q > NW'(sw_r - DW'(1))) ? sw_r - DW'(1) : DW'(div_q);
      default: q_clamp = (div_q > NW'(sh_r - DW'(1))) ? sh_r - DW'(1) : DW'(div_q);
    endcase
  end

  lbr_div #(.NW(NW), .DENW(DENW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_q)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (head_valid) begin
        if (head.func == FN_WRITE) state_nxt = ST_IDLE;
        else if (setup_valid_r) state_nxt = ST_POS;
        else state_nxt = ST_SETUP;
      end
      ST_SETUP: state_nxt = ST_DGO;
      ST_DGO:   state_nxt = ST_DWAIT;
      ST_DWAIT: if (div_done) begin
        case (kind_r)
          DK_RH:   state_nxt = ST_OFFS;
          DK_SY:   state_nxt = ST_READ;
          default: state_nxt = ST_DGO;
        endcase
      end
      ST_OFFS: state_nxt = ST_POS;
      ST_POS:  state_nxt = pad_c ? ST_OUT : ST_DGO;
      ST_READ: state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop       = (state_r == ST_IDLE) && head_valid;
    wr_en     = pop && (head.func == FN_WRITE) &&
                (32'(head.write_x) < MAX_SRC_W) && (32'(head.write_y) < MAX_SRC_H);
    div_start = (state_r == ST_DGO);
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= {head.red, head.green, head.blue};
    if (state_r == ST_READ) rd_data_r <= mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_SETUP: begin
        sw_r <= sw_c; sh_r <= sh_c; tw_r <= tw_c; th_r <= th_c;
        if ((2*DW)'(tw_c) * (2*DW)'(sh_c) < (2*DW)'(th_c) * (2*DW)'(sw_c)) begin
          sn_r <= tw_c; sd_r <= sw_c;
        end else begin
          sn_r <= th_c; sd_r <= sh_c;
        end
      end
      ST_DWAIT: if (div_done) begin
        case (kind_r)
          DK_RW:   rw_r <= q_clamp;
          DK_RH:   rh_r <= q_clamp;
          DK_SX:   sx_r <= q_clamp;
          default: rd_addr_r <= AW'(32'(q_clamp) * MAX_SRC_W + 32'(sx_r));
        endcase
      end
      ST_OFFS: begin
        offx_r <= (tw_r - rw_r) >> 1;
        offy_r <= (th_r - rh_r) >> 1;
      end
      ST_POS: is_pad_r <= pad_c;
      default: ;
    endcase
    if (state_r == ST_OUT && out_free) begin
      opix_r  <= is_pad_r ? {pad_r, pad_r, pad_r} : rd_data_r;
      ocol_r  <= COL_W'(cx_r);
      orow_r  <= COL_W'(cy_r);
      opad_r  <= is_pad_r;
      olast_r <= last_c;
    end
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      kind_r        <= DK_RW;
      setup_valid_r <= 1'b0;
      cx_r <= '0; cy_r <= '0;
      rw_r <= '0; rh_r <= '0; offx_r <= '0; offy_r <= '0;
      tw_r <= DW'(1); th_r <= DW'(1);
      ov_r <= 1'b0;
      src_w_r <= SRC_REG_W'(128); src_h_r <= SRC_REG_W'(128);
      dst_w_r <= DST_REG_W'(640); dst_h_r <= DST_REG_W'(640);
      pad_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_ch.ready) ov_r <= 1'b0;
      case (state_r)
        ST_SETUP: kind_r <= DK_RW;
        ST_DWAIT: if (div_done) begin
          case (kind_r)
            DK_RW:   kind_r <= DK_RH;
            DK_SX:   kind_r <= DK_SY;
            default: ;
          endcase
        end
        ST_OFFS: setup_valid_r <= 1'b1;
        ST_POS: begin
          cx_r   <= cx_e;
          cy_r   <= cy_e;
          kind_r <= DK_SX;
        end
        ST_OUT: if (out_free) begin
          ov_r <= 1'b1;
          if (last_c) begin
            cx_r <= '0; cy_r <= '0; setup_valid_r <= 1'b0;
          end else if (cx_r + DW'(1) >= tw_r) begin
            cx_r <= '0; cy_r <= cy_r + DW'(1);
          end else begin
            cx_r <= cx_r + DW'(1);
          end
        end
        default: ;
      endcase
      if (cfg_hit) begin
        cx_r <= '0; cy_r <= '0; setup_valid_r <= 1'b0;
        case (cfg_index)
          CFG_SRC_W: src_w_r <= SRC_REG_W'(cfg_data);
          CFG_SRC_H: src_h_r <= SRC_REG_W'(cfg_data);
          CFG_DST_W: dst_w_r <= cfg_data;
          CFG_DST_H: dst_h_r <= cfg_data;
          default:   pad_r   <= PAD_REG_W'(cfg_data);
        endcase
      end
    end
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.out_red    = opix_r[23:16];
  assign out_ch.out_green  = opix_r[15:8];
  assign out_ch.out_blue   = opix_r[7:0];
  assign out_ch.col        = ocol_r;
  assign out_ch.row        = orow_r;
  assign out_ch.is_padding = opad_r;
  assign out_ch.frame_end  = olast_r;

  a_pos_after_setup: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_POS |-> setup_valid_r) else $error("pixel without setup");
  a_read_inside: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |-> !is_pad_r) else $error("store read for padding");
  a_cursor_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT |-> (cx_r < tw_r && cy_r < th_r)) else $error("cursor outside");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DWAIT) else $error("stray divider result");
endmodule
`default_nettype wire

### hw/rtl/letterbox_nearest_resize_unit.sv
// ----------------------------------------------------------------------------
// letterbox_nearest_resize_unit
// frame store plus letterboxed nearest neighbor output stream
// ----------------------------------------------------------------------------
// write item: queued, stored on pop; one per cycle while no emit item is ahead
// emit item, padding: queue, idle, position and output states, output register
// emit item, inside area: also two runs of the shared bit-serial divider
//   (NW = 2*dim bits + 2, 24 by default) for two source indices, store read
// first emit of a frame adds the two resize setup divisions
// rst_n synchronous: registers to defaults, cursor zero, frame store not cleared
`default_nettype none
module letterbox_nearest_resize_unit #(
  parameter int MAX_SRC_W   = lbr_pkg::MAX_SRC_W_DEF,
  parameter int MAX_SRC_H   = lbr_pkg::MAX_SRC_H_DEF,
  parameter int MAX_DST_DIM = lbr_pkg::MAX_DST_DIM_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  lbr_in_if.sink                              in_ch,
  lbr_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [lbr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lbr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lbr_pkg::*;

  // queue head between front and back
  item_t head;
  logic  head_valid;
  logic  pop;

  // front: accepts items into a two-entry queue
  lbr_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .head(head), .head_valid(head_valid), .pop(pop)
  );

  // back: store writes, setup division, index division, output register
  lbr_back #(
    .MAX_SRC_W(MAX_SRC_W), .MAX_SRC_H(MAX_SRC_H), .MAX_DST_DIM(MAX_DST_DIM)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .head(head), .head_valid(head_valid), .pop(pop),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .out_ch(out_ch)
  );
endmodule
`default_nettype wire
